// ===== design/mio0_lz_decompressor_macros.svh =====
// ----------------------------------------------------------------------------
// MIO0 decompressor assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MIO0_LZ_DECOMPRESSOR_MACROS_SVH
`define MIO0_LZ_DECOMPRESSOR_MACROS_SVH

`ifndef ASSERT_OFF

`define MLZ_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`define MLZ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`else

`define MLZ_ASSERT_ALWAYS(label, clk, rst, prop, msg)

`define MLZ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/mlz_pkg.sv =====
// ----------------------------------------------------------------------------
// MIO0 decompressor package
// Shared widths, token and error codes, state and command types.
// ----------------------------------------------------------------------------
`default_nettype none

package mlz_pkg;

   localparam int WINDOW_DEPTH = 4096;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

   localparam int SIZE_W    = 24;
   localparam int WORD_W    = 32;
   localparam int BYTE_W    = 8;
   localparam int PAIR_W    = 16;
   localparam int OFS_W     = 12;
   localparam int DIST_W    = OFS_W + 1;
   localparam int CNT_W     = 5;
   localparam int BITS_W    = 6;
   localparam int CTRL_BITS = 32;
   localparam int MIN_MATCH = 3;

   typedef enum logic [1:0] {
      KIND_CTRL = 2'd0,
      KIND_RAW  = 2'd1,
      KIND_PAIR = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OK           = 2'd0,
      ERR_KIND         = 2'd1,
      ERR_FINISHED     = 2'd2,
      ERR_BEFORE_START = 2'd3
   } err_type;

   typedef enum logic {
      ST_IDLE,
      ST_COPY
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_STATUS,
      OP_CTRL,
      OP_RAW,
      OP_PAIR,
      OP_COPY
   } op_type;

   typedef struct packed {
      op_type  op;
      err_type err;
   } cmd_type;

   typedef struct packed {
      kind_type need;
      logic     done;
      logic     copy_last;
      logic     rsp_full;
   } stat_type;

endpackage

`default_nettype wire

// ===== design/mlz_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mlz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/mlz_ctrl.sv =====
// ----------------------------------------------------------------------------
// MIO0 decompressor controller
// Classifies each token and sequences back-reference copies one byte a cycle while the result register is free to load.
// ----------------------------------------------------------------------------
`default_nettype none

module mlz_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_type,
   output logic                  req_ready,
   input  wire logic             rsp_ready,
   input  wire mlz_pkg::stat_type stat,
   output mlz_pkg::cmd_type      cmd
);

   mlz_pkg::state_type state_ff, state_in;
   logic load_ok;

   assign load_ok = !stat.rsp_full || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlz_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.op    = mlz_pkg::OP_NONE;
      cmd.err   = mlz_pkg::ERR_OK;
      unique case (state_ff)
         mlz_pkg::ST_IDLE: begin
            req_ready = load_ok;
            if (req_valid && load_ok) begin
               if (stat.done) begin
                  cmd.op  = mlz_pkg::OP_STATUS;
                  cmd.err = mlz_pkg::ERR_FINISHED;
               end else if (req_type != stat.need) begin
                  cmd.op  = mlz_pkg::OP_STATUS;
                  cmd.err = mlz_pkg::ERR_KIND;
               end else begin
                  unique case (mlz_pkg::kind_type'(req_type))
                     mlz_pkg::KIND_CTRL: cmd.op = mlz_pkg::OP_CTRL;
                     mlz_pkg::KIND_RAW:  cmd.op = mlz_pkg::OP_RAW;
                     mlz_pkg::KIND_PAIR: begin
                        cmd.op   = mlz_pkg::OP_PAIR;
                        state_in = mlz_pkg::ST_COPY;
                     end
                     default: begin
                        cmd.op  = mlz_pkg::OP_STATUS;
                        cmd.err = mlz_pkg::ERR_KIND;
                     end
                  endcase
               end
            end
         end
         mlz_pkg::ST_COPY: begin
            if (load_ok) begin
               cmd.op = mlz_pkg::OP_COPY;
               if (stat.copy_last) begin
                  state_in = mlz_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = mlz_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/mlz_datapath.sv =====
// ----------------------------------------------------------------------------
// MIO0 decompressor datapath
// Control word, counters, history window and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mio0_lz_decompressor_macros.svh"

module mlz_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   input  wire logic [mlz_pkg::SIZE_W-1:0]  csr_out_size,
   input  wire logic [mlz_pkg::WORD_W-1:0]  req_payload,
   input  wire mlz_pkg::cmd_type            cmd,
   input  wire logic                        rsp_ready,
   output mlz_pkg::stat_type                stat,
   output logic                             rsp_valid,
   output logic [mlz_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                             rsp_byte_valid,
   output logic                             rsp_run_last,
   output logic                             rsp_finished,
   output logic [1:0]                       rsp_need_next,
   output logic [1:0]                       rsp_error_code
);

   localparam int AW = mlz_pkg::WIN_AW;

   logic [mlz_pkg::SIZE_W-1:0]  out_size_ff;
   logic [mlz_pkg::WORD_W-1:0]  shift_ff;
   logic [mlz_pkg::BITS_W-1:0]  bits_ff;
   logic [mlz_pkg::SIZE_W-1:0]  bp_ff;
   logic                        done_ff;
   logic [mlz_pkg::DIST_W-1:0]  dist_ff;
   logic [mlz_pkg::CNT_W-1:0]   cnt_ff;
   logic                        first_ff;
   logic [mlz_pkg::BYTE_W-1:0]  last_byte_ff;
   logic [AW-1:0]               rd_addr_ff;
   logic                        item_done_ff;
   mlz_pkg::kind_type           item_need_ff;
   mlz_pkg::err_type            item_err_ff;

   logic                        rsp_valid_ff;
   logic [mlz_pkg::BYTE_W-1:0]  rsp_byte_ff;
   logic                        rsp_bvalid_ff;
   logic                        rsp_last_ff;
   logic                        rsp_fin_ff;
   mlz_pkg::kind_type           rsp_need_ff;
   mlz_pkg::err_type            rsp_err_ff;

   mlz_pkg::kind_type           need_cur;
   logic [mlz_pkg::SIZE_W-1:0]  rem;
   logic [mlz_pkg::PAIR_W-1:0]  pair;
   logic [mlz_pkg::CNT_W-1:0]   raw_cnt;
   logic [mlz_pkg::CNT_W-1:0]   cnt_new;
   logic [mlz_pkg::DIST_W-1:0]  dist_new;
   logic                        done_pair;
   logic                        done_raw;
   logic [mlz_pkg::WORD_W-1:0]  shift_used;
   logic [mlz_pkg::BITS_W-1:0]  bits_used;
   mlz_pkg::err_type            err_pair;
   logic                        src_zero;
   logic [mlz_pkg::BYTE_W-1:0]  copy_byte;
   logic                        load;

   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [mlz_pkg::BYTE_W-1:0]  ram_wr_data;
   logic                        ram_rd_en;
   logic [AW-1:0]               ram_rd_addr;
   logic [mlz_pkg::BYTE_W-1:0]  ram_rd_data;

   function automatic mlz_pkg::kind_type need_after(
      input logic                       done_after,
      input logic [mlz_pkg::BITS_W-1:0] bits,
      input logic                       msb
   );
      mlz_pkg::kind_type k;
      if (done_after) begin
         k = mlz_pkg::KIND_NONE;
      end else if (bits == '0) begin
         k = mlz_pkg::KIND_CTRL;
      end else if (msb) begin
         k = mlz_pkg::KIND_RAW;
      end else begin
         k = mlz_pkg::KIND_PAIR;
      end
      return k;
   endfunction

   always_comb begin
      need_cur   = need_after(done_ff, bits_ff, shift_ff[mlz_pkg::WORD_W-1]);
      rem        = out_size_ff - bp_ff;
      pair       = req_payload[mlz_pkg::PAIR_W-1:0];
      raw_cnt    = mlz_pkg::CNT_W'(pair[mlz_pkg::PAIR_W-1:mlz_pkg::OFS_W])
                   + mlz_pkg::CNT_W'(mlz_pkg::MIN_MATCH);
      dist_new   = mlz_pkg::DIST_W'(pair[mlz_pkg::OFS_W-1:0]) + mlz_pkg::DIST_W'(1);
      done_pair  = mlz_pkg::SIZE_W'(raw_cnt) >= rem;
      cnt_new    = done_pair ? rem[mlz_pkg::CNT_W-1:0] : raw_cnt;
      done_raw   = rem == mlz_pkg::SIZE_W'(1);
      shift_used = shift_ff << 1;
      bits_used  = bits_ff - mlz_pkg::BITS_W'(1);
      err_pair   = (bp_ff < mlz_pkg::SIZE_W'(dist_new)) ? mlz_pkg::ERR_BEFORE_START
                                                          : mlz_pkg::ERR_OK;
      src_zero   = bp_ff < mlz_pkg::SIZE_W'(dist_ff);
      if (src_zero) begin
         copy_byte = '0;
      end else if (!first_ff && dist_ff == mlz_pkg::DIST_W'(1)) begin
         copy_byte = last_byte_ff;
      end else begin
         copy_byte = ram_rd_data;
      end
      load = cmd.op == mlz_pkg::OP_STATUS || cmd.op == mlz_pkg::OP_CTRL ||
             cmd.op == mlz_pkg::OP_RAW || cmd.op == mlz_pkg::OP_COPY;

      ram_wr_en   = cmd.op == mlz_pkg::OP_RAW || cmd.op == mlz_pkg::OP_COPY;
      ram_wr_addr = bp_ff[AW-1:0];
      ram_wr_data = (cmd.op == mlz_pkg::OP_RAW) ? req_payload[mlz_pkg::BYTE_W-1:0]
                                                : copy_byte;
      ram_rd_en   = cmd.op == mlz_pkg::OP_PAIR || cmd.op == mlz_pkg::OP_COPY;
      ram_rd_addr = (cmd.op == mlz_pkg::OP_PAIR) ? bp_ff[AW-1:0] - AW'(dist_new)
                                                 : rd_addr_ff + AW'(1);
   end

   mlz_ram #(
      .WIDTH (mlz_pkg::BYTE_W),
      .DEPTH (mlz_pkg::WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_size_ff  <= '0;
         shift_ff     <= '0;
         bits_ff      <= '0;
         bp_ff        <= '0;
         done_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            out_size_ff <= csr_out_size;
            shift_ff    <= '0;
            bits_ff     <= '0;
            bp_ff       <= '0;
            done_ff     <= csr_out_size == '0;
         end else begin
            case (cmd.op)
               mlz_pkg::OP_CTRL: begin
                  shift_ff <= req_payload;
                  bits_ff  <= mlz_pkg::BITS_W'(mlz_pkg::CTRL_BITS);
               end
               mlz_pkg::OP_RAW: begin
                  shift_ff <= shift_used;
                  bits_ff  <= bits_used;
                  bp_ff    <= bp_ff + mlz_pkg::SIZE_W'(1);
                  done_ff  <= done_raw;
               end
               mlz_pkg::OP_PAIR: begin
                  shift_ff <= shift_used;
                  bits_ff  <= bits_used;
                  done_ff  <= done_pair;
               end
               mlz_pkg::OP_COPY: begin
                  bp_ff <= bp_ff + mlz_pkg::SIZE_W'(1);
               end
               default: ;
            endcase
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         mlz_pkg::OP_STATUS: begin
            rsp_byte_ff   <= '0;
            rsp_bvalid_ff <= 1'b0;
            rsp_last_ff   <= 1'b1;
            rsp_fin_ff    <= done_ff;
            rsp_need_ff   <= need_cur;
            rsp_err_ff    <= cmd.err;
         end
         mlz_pkg::OP_CTRL: begin
            rsp_byte_ff   <= '0;
            rsp_bvalid_ff <= 1'b0;
            rsp_last_ff   <= 1'b1;
            rsp_fin_ff    <= 1'b0;
            rsp_need_ff   <= req_payload[mlz_pkg::WORD_W-1] ? mlz_pkg::KIND_RAW
                                                             : mlz_pkg::KIND_PAIR;
            rsp_err_ff    <= mlz_pkg::ERR_OK;
         end
         mlz_pkg::OP_RAW: begin
            rsp_byte_ff   <= req_payload[mlz_pkg::BYTE_W-1:0];
            rsp_bvalid_ff <= 1'b1;
            rsp_last_ff   <= 1'b1;
            rsp_fin_ff    <= done_raw;
            rsp_need_ff   <= need_after(done_raw, bits_used, shift_used[mlz_pkg::WORD_W-1]);
            rsp_err_ff    <= mlz_pkg::ERR_OK;
            last_byte_ff  <= req_payload[mlz_pkg::BYTE_W-1:0];
         end
         mlz_pkg::OP_PAIR: begin
            dist_ff      <= dist_new;
            cnt_ff       <= cnt_new;
            first_ff     <= 1'b1;
            rd_addr_ff   <= ram_rd_addr;
            item_done_ff <= done_pair;
            item_need_ff <= need_after(done_pair, bits_used, shift_used[mlz_pkg::WORD_W-1]);
            item_err_ff  <= err_pair;
         end
         mlz_pkg::OP_COPY: begin
            rsp_byte_ff   <= copy_byte;
            rsp_bvalid_ff <= 1'b1;
            rsp_last_ff   <= cnt_ff == mlz_pkg::CNT_W'(1);
            rsp_fin_ff    <= item_done_ff;
            rsp_need_ff   <= item_need_ff;
            rsp_err_ff    <= item_err_ff;
            last_byte_ff  <= copy_byte;
            cnt_ff        <= cnt_ff - mlz_pkg::CNT_W'(1);
            first_ff      <= 1'b0;
            rd_addr_ff    <= ram_rd_addr;
         end
         default: ;
      endcase
   end

   assign stat.need      = need_cur;
   assign stat.done      = done_ff;
   assign stat.copy_last = cnt_ff == mlz_pkg::CNT_W'(1);
   assign stat.rsp_full  = rsp_valid_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_finished   = rsp_fin_ff;
   assign rsp_need_next  = rsp_need_ff;
   assign rsp_error_code = rsp_err_ff;

   `MLZ_ASSERT_ALWAYS(a_bp_in_range, clock, reset, bp_ff <= out_size_ff,
      "bytes produced passed out_size")

   `MLZ_ASSERT_IMPLY(a_load_slot_free, clock, reset, load, !rsp_valid_ff || rsp_ready,
      "result register overwritten before transfer")

   `MLZ_ASSERT_IMPLY(a_status_is_last, clock, reset, rsp_valid_ff && !rsp_bvalid_ff,
      rsp_last_ff, "status result not marked last")

   `MLZ_ASSERT_IMPLY(a_copy_count, clock, reset, cmd.op == mlz_pkg::OP_COPY,
      cnt_ff != '0, "copy step with empty count")

   `MLZ_ASSERT_IMPLY(a_finished_need, clock, reset, rsp_valid_ff && rsp_fin_ff,
      rsp_need_ff == mlz_pkg::KIND_NONE, "finished result still wants a token")

endmodule

`default_nettype wire

// ===== design/mio0_lz_decompressor.sv =====
// ----------------------------------------------------------------------------
// MIO0 decompressor
// Token-fed MIO0 decoder: control words, raw bytes and back-reference pairs
// in, one decompressed byte or one status word per result out.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// csr_      in         csr_valid / csr_ready  csr_out_size
// req_      in         req_valid / req_ready  req_type, req_payload
// rsp_      out        rsp_valid / rsp_ready  rsp_out_byte .. rsp_error_code
//
// Control word, raw byte and status items give one result each; a pair is
// taken, then its n bytes (1 to 18) are copied one at a time through the
// single read port of the history window and one result register.
// Reset (synchronous) leaves the block finished until out_size is written.
// A stalled rsp_ready holds the result register and the copy in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module mio0_lz_decompressor (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [mlz_pkg::SIZE_W-1:0] csr_out_size,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_type,
   input  wire logic [mlz_pkg::WORD_W-1:0] req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [mlz_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_byte_valid,
   output logic                            rsp_run_last,
   output logic                            rsp_finished,
   output logic [1:0]                      rsp_need_next,
   output logic [1:0]                      rsp_error_code
);

   mlz_pkg::cmd_type  cmd;
   mlz_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   mlz_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mlz_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_out_size   (csr_out_size),
      .req_payload    (req_payload),
      .cmd            (cmd),
      .rsp_ready      (rsp_ready),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_finished   (rsp_finished),
      .rsp_need_next  (rsp_need_next),
      .rsp_error_code (rsp_error_code)
   );

endmodule

`default_nettype wire

// ===== dv/mio0_lz_decompressor_test.sv =====
// ----------------------------------------------------------------------------
// MIO0 decompressor testbench
// Feeds control words, raw bytes and back-reference pairs through the request
// channel under random sender bursts and receiver stalls. The expected
// results come from a token-level model of the decoder with its own history
// window. Each result is checked field by field in order. The output length
// is rewritten between phases, using zero, one, the largest length and
// random lengths.
// ----------------------------------------------------------------------------
module mio0_lz_decompressor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mlz_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              run_last;
      logic              finished;
      logic [1:0]        need_next;
      logic [1:0]        error_code;
   } outcome_type;

   class tracker_type;
      logic [BYTE_W-1:0] window [WINDOW_DEPTH];
      int unsigned       length;
      logic [WORD_W-1:0] ctrl_word;
      int unsigned       ctrl_left;
      int unsigned       produced;
      bit                done;
      outcome_type       fresh[$];
      outcome_type       bytes_due[$];
      int                mismatches;

      function new();
         mismatches = 0;
         restart(0);
      endfunction

      function void restart(int unsigned size);
         length    = size;
         ctrl_word = '0;
         ctrl_left = 0;
         produced  = 0;
         done      = (size == 0);
      endfunction

      function kind_type need();
         if (done)
            return KIND_NONE;
         if (ctrl_left == 0)
            return KIND_CTRL;
         return ctrl_word[WORD_W-1] ? KIND_RAW : KIND_PAIR;
      endfunction

      function int due();
         return bytes_due.size();
      endfunction

      function void emit(logic [BYTE_W-1:0] value);
         outcome_type r;
         window[produced % WINDOW_DEPTH] = value;
         produced++;
         if (produced >= length)
            done = 1'b1;
         r = '0;
         r.out_byte   = value;
         r.byte_valid = 1'b1;
         fresh = {fresh, r};
      endfunction

      function void consume_bit();
         ctrl_word = ctrl_word << 1;
         if (ctrl_left > 0)
            ctrl_left--;
      endfunction

      function void take_token(logic [1:0] kind, logic [WORD_W-1:0] payload);
         err_type           err;
         logic [PAIR_W-1:0] pair;
         int unsigned       count;
         int unsigned       span;
         logic [BYTE_W-1:0] value;
         outcome_type       r;
         err = ERR_OK;
         fresh.delete();
         if (done) begin
            err = ERR_FINISHED;
         end else if (kind != need()) begin
            err = ERR_KIND;
         end else begin
            case (kind_type'(kind))
               KIND_CTRL: begin
                  ctrl_word = payload;
                  ctrl_left = CTRL_BITS;
               end
               KIND_RAW: begin
                  emit(payload[BYTE_W-1:0]);
                  consume_bit();
               end
               default: begin
                  pair  = payload[PAIR_W-1:0];
                  count = pair[PAIR_W-1:OFS_W] + MIN_MATCH;
                  span  = pair[OFS_W-1:0] + 1;
                  if (count > length - produced)
                     count = length - produced;
                  if (produced < span)
                     err = ERR_BEFORE_START;
                  for (int i = 0; i < count; i++) begin
                     value = '0;
                     if (produced >= span)
                        value = window[(produced - span) % WINDOW_DEPTH];
                     emit(value);
                  end
                  consume_bit();
               end
            endcase
         end
         if (fresh.size() == 0) begin
            r = '0;
            fresh = {fresh, r};
         end
         foreach (fresh[k]) begin
            r            = fresh[k];
            r.run_last   = (k == fresh.size() - 1);
            r.finished   = done;
            r.need_next  = need();
            r.error_code = err;
            bytes_due = {bytes_due, r};
         end
      endfunction

      function void compare(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
         if (got !== want) begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void match_output(outcome_type got);
         outcome_type want;
         if (bytes_due.size() == 0) begin
            $display("%0t result with nothing due: expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = bytes_due.pop_front();
         compare("out_byte", want.out_byte, got.out_byte);
         compare("byte_valid", want.byte_valid, got.byte_valid);
         compare("run_last", want.run_last, got.run_last);
         compare("finished", want.finished, got.finished);
         compare("need_next", want.need_next, got.need_next);
         compare("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              csr_valid      = 1'b0;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_out_size   = '0;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [1:0]        req_type       = '0;
   logic [WORD_W-1:0] req_payload    = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_byte_valid;
   logic              rsp_run_last;
   logic              rsp_finished;
   logic [1:0]        rsp_need_next;
   logic [1:0]        rsp_error_code;

   tracker_type    tracker;
   int             burst_left = 0;
   int             stall_mode = 0;
   int             mode_left  = 0;
   int             stall_left = 0;

   mio0_lz_decompressor i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_out_size   (csr_out_size),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_finished   (rsp_finished),
      .rsp_need_next  (rsp_need_next),
      .rsp_error_code (rsp_error_code)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_left > 0) begin
               rsp_ready  <= 1'b0;
               stall_left <= stall_left - 1;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 9) == 0)
                  stall_left <= $urandom_range(5, 20);
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.match_output({rsp_out_byte, rsp_byte_valid, rsp_run_last, rsp_finished,
                               rsp_need_next, rsp_error_code});
   end

   task automatic send_token(logic [1:0] kind, logic [WORD_W-1:0] payload);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_payload <= payload;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      tracker.take_token(kind, payload);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.due() != 0)
         @(posedge clock);
   endtask

   task automatic write_size(logic [SIZE_W-1:0] size);
      csr_valid    <= 1'b1;
      csr_out_size <= size;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      tracker.restart(size);
   endtask

   task automatic fill_phase(logic [SIZE_W-1:0] size, int items, bit heavy);
      logic [1:0]        kind;
      logic [WORD_W-1:0] payload;
      int                spent;
      spent = 0;
      write_size(size);
      for (int i = 0; i < items; i++) begin
         if (tracker.need() == KIND_NONE) begin
            if (spent >= 2)
               break;
            spent++;
            kind = 2'($urandom_range(0, 3));
         end else if ($urandom_range(0, 9) == 0) begin
            kind = 2'($urandom_range(0, 3));
         end else begin
            kind = tracker.need();
         end
         payload = $urandom;
         if (kind == KIND_CTRL && heavy)
            payload = $urandom & $urandom & $urandom & $urandom;
         if (kind == KIND_PAIR) begin
            if (heavy && $urandom_range(0, 7) != 0)
               payload[PAIR_W-1:OFS_W] = '1;
            if ($urandom_range(0, 1))
               payload[OFS_W-1:0] = OFS_W'($urandom_range(0, 31));
         end
         if (heavy && i == items / 2)
            wait_drained();
         send_token(kind, payload);
      end
      wait_drained();
   endtask

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_token(KIND_CTRL, 32'hFFFF_FFFF);
      send_token(KIND_NONE, 32'h0000_0000);
      wait_drained();
      write_size(24'd0);
      send_token(KIND_RAW, 32'h0000_0000);
      wait_drained();

      write_size(24'd5);
      send_token(KIND_NONE, 32'h5A5A_5A5A);
      send_token(KIND_RAW, 32'h0000_0011);
      send_token(KIND_CTRL, 32'h4000_0000);
      send_token(KIND_RAW, 32'h0000_0000);
      send_token(KIND_PAIR, 32'hFFFF_0000);
      send_token(KIND_RAW, 32'hFFFF_FFFF);
      send_token(KIND_PAIR, 32'h0000_FFFF);
      send_token(KIND_PAIR, 32'h0000_0000);
      wait_drained();

      write_size(24'hFF_FFFF);
      send_token(KIND_CTRL, 32'hC000_0000);
      send_token(KIND_RAW, 32'h0000_0012);
      send_token(KIND_RAW, 32'h0000_0034);
      send_token(KIND_PAIR, 32'h0000_F001);
      send_token(KIND_PAIR, 32'h0000_0000);
      send_token(KIND_PAIR, 32'h0000_0013);
      send_token(KIND_PAIR, 32'h0000_5FFF);
      send_token(KIND_CTRL, 32'h8000_0001);
      wait_drained();

      fill_phase(SIZE_W'($urandom_range(20, 200)), 50, 1'b0);
      fill_phase(24'hFF_FFFF, 300, 1'b1);
      fill_phase(24'd1, 4, 1'b0);
      fill_phase(SIZE_W'($urandom_range(2, 40)), 30, 1'b0);
      fill_phase(SIZE_W'($urandom_range(100, 600)), 40, 1'b0);

      repeat (40) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
